FILE: rtl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and microcode for the trial division factorizer
// Control word layout, opcode and condition codes, step addresses and the
// read-only microprogram that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

    typedef logic [3:0] t_pc;

    // datapath actions
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,       // take input, reset scratch state
        OP_PUSH_R0,    // result for inputs 0 and 1
        OP_DIV_START,  // load divider with remainder
        OP_DIV_STEP,   // one quotient bit
        OP_DIV_APPLY,  // remainder <= quotient, exponent + 1
        OP_STAGE,      // hold (divisor, exponent), release older held result
        OP_STAGE_R,    // hold (remainder, 1), release older held result
        OP_FLUSH,      // release held result as last
        OP_NEXT_D      // next trial divisor
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OUT_BUSY,
        C_R_LE1,
        C_LOOP_DONE,
        C_DIV_BUSY,
        C_REM_NZ,
        C_E_ZERO
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_cw;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctl;

    // step addresses
    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_SMALLQ = 4'd1;
    localparam t_pc PC_LOOP   = 4'd2;
    localparam t_pc PC_DIVS   = 4'd3;
    localparam t_pc PC_DIVW   = 4'd4;
    localparam t_pc PC_REMQ   = 4'd5;
    localparam t_pc PC_APPLY  = 4'd6;
    localparam t_pc PC_EQ     = 4'd7;
    localparam t_pc PC_STAGE  = 4'd8;
    localparam t_pc PC_NEXT   = 4'd9;
    localparam t_pc PC_TAIL   = 4'd10;
    localparam t_pc PC_STG_R  = 4'd11;
    localparam t_pc PC_FLUSH  = 4'd12;
    localparam t_pc PC_DONE   = 4'd13;
    localparam t_pc PC_SMALL  = 4'd14;
    localparam t_pc PC_SDONE  = 4'd15;

    // jump taken when cond holds, else fall through to pc + 1
    function automatic t_cw tdf_rom(input t_pc pc);
        t_cw cw;
        cw = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:   cw = '{op: OP_LOAD,      cond: C_NO_IN,     target: PC_IDLE};
            PC_SMALLQ: cw = '{op: OP_NOP,       cond: C_R_LE1,     target: PC_SMALL};
            PC_LOOP:   cw = '{op: OP_NOP,       cond: C_LOOP_DONE, target: PC_TAIL};
            PC_DIVS:   cw = '{op: OP_DIV_START, cond: C_NEVER,     target: PC_IDLE};
            PC_DIVW:   cw = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY,  target: PC_DIVW};
            PC_REMQ:   cw = '{op: OP_NOP,       cond: C_REM_NZ,    target: PC_EQ};
            PC_APPLY:  cw = '{op: OP_DIV_APPLY, cond: C_ALWAYS,    target: PC_DIVS};
            PC_EQ:     cw = '{op: OP_NOP,       cond: C_E_ZERO,    target: PC_NEXT};
            PC_STAGE:  cw = '{op: OP_STAGE,     cond: C_OUT_BUSY,  target: PC_STAGE};
            PC_NEXT:   cw = '{op: OP_NEXT_D,    cond: C_ALWAYS,    target: PC_LOOP};
            PC_TAIL:   cw = '{op: OP_NOP,       cond: C_R_LE1,     target: PC_FLUSH};
            PC_STG_R:  cw = '{op: OP_STAGE_R,   cond: C_OUT_BUSY,  target: PC_STG_R};
            PC_FLUSH:  cw = '{op: OP_FLUSH,     cond: C_OUT_BUSY,  target: PC_FLUSH};
            PC_DONE:   cw = '{op: OP_NOP,       cond: C_ALWAYS,    target: PC_IDLE};
            PC_SMALL:  cw = '{op: OP_PUSH_R0,   cond: C_OUT_BUSY,  target: PC_SMALL};
            PC_SDONE:  cw = '{op: OP_NOP,       cond: C_ALWAYS,    target: PC_IDLE};
            default:   cw = '{op: OP_NOP,       cond: C_ALWAYS,    target: PC_IDLE};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer: microcoded trial division prime factorizer
// Splits one unsigned value into its prime factors with exponents.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (i_in_valid / o_in_ready, i_value): one number per transfer.
//   Only the low VALUE_BITS bits (at most 32) are used.
//   Output channel (o_out_valid / i_out_ready): one transfer per distinct
//   prime factor, ascending, with o_exponent; o_last flags the final one.
//   Inputs 0 and 1 give one transfer: factor = input, exponent 0, last 1.
// Operation:
//   A 16-step microprogram drives a bit-serial divider. Each trial divisor
//   takes a divider pass plus bookkeeping; each power divided out adds
//   another divider pass. A 32-bit prime near 2^32 tries about 65535
//   divisors. One number is in work at a time; o_in_ready is high only
//   in the idle step.
// Output:
//   A found factor is held one step back until it is known whether another
//   follows, then moved into the output register. When the receiver stalls
//   the sequencer waits at its next output step; the held register keeps
//   o_out_valid and payload stable until the transfer.
// Reset:
//   Synchronous, active low; sequencer returns to idle, output goes invalid.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [31:0] o_factor,
    output logic      [4:0]  o_exponent,
    output logic             o_last
);
    import tdf_pkg::*;

    // remainder width, divisor width (covers sqrt of remainder), square width
    localparam int RW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int DW = RW / 2 + 1;
    localparam int SW = 2 * DW;
    localparam int FIRST_DIV = 2;

    t_pc           r_pc, n_pc;
    t_cw           cw;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [SW-1:0] r_sq;      // r_div squared, tracked incrementally
    logic [4:0]    r_exp;

    // held result, released once the next one (or the end) is known
    logic          r_pend_v;
    logic [31:0]   r_pend_f;
    logic [4:0]    r_pend_e;

    logic          r_ov;
    logic [31:0]   r_of;
    logic [4:0]    r_oe;
    logic          r_ol;

    t_div_ctl      div_ctl;
    logic [RW-1:0] div_quot;
    logic [DW-1:0] div_rem;
    logic          div_busy;

    logic          out_free;
    logic          rem_le1;
    logic          jump;
    logic          push;
    logic [31:0]   push_f;
    logic [4:0]    push_e;
    logic          push_l;

    assign cw       = tdf_rom(r_pc);
    assign out_free = !r_ov || i_out_ready;
    assign rem_le1  = r_rem <= RW'(1);

    assign div_ctl.start = cw.op == OP_DIV_START;
    assign div_ctl.step  = cw.op == OP_DIV_STEP;

    tdf_div #(
        .RW (RW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_rem),
        .i_divisor  (r_div),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_busy     (div_busy)
    );

    // condition select and next step
    always_comb begin
        unique case (cw.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_IN:     jump = !i_in_valid;
            C_OUT_BUSY:  jump = !out_free;
            C_R_LE1:     jump = rem_le1;
            C_LOOP_DONE: jump = rem_le1 || (r_sq > {{(SW-RW){1'b0}}, r_rem});
            C_DIV_BUSY:  jump = div_busy;
            C_REM_NZ:    jump = div_rem != '0;
            C_E_ZERO:    jump = r_exp == '0;
            default:     jump = 1'b0;
        endcase
        n_pc = jump ? cw.target : r_pc + 1'b1;
    end

    // result going into the output register this cycle
    always_comb begin
        push   = 1'b0;
        push_f = r_pend_f;
        push_e = r_pend_e;
        push_l = 1'b0;
        case (cw.op)
            OP_PUSH_R0: begin
                push   = out_free;
                push_f = 32'(r_rem);
                push_e = '0;
                push_l = 1'b1;
            end
            OP_STAGE, OP_STAGE_R: begin
                push = out_free && r_pend_v;
            end
            OP_FLUSH: begin
                push   = out_free && r_pend_v;
                push_l = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // held-result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else begin
            case (cw.op)
                OP_LOAD:              if (i_in_valid) r_pend_v <= 1'b0;
                OP_STAGE, OP_STAGE_R: if (out_free)   r_pend_v <= 1'b1;
                OP_FLUSH:             if (out_free)   r_pend_v <= 1'b0;
                default:              r_pend_v <= r_pend_v;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_of <= push_f;
            r_oe <= push_e;
            r_ol <= push_l;
        end
        case (cw.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    r_rem <= i_value[RW-1:0];
                    r_div <= DW'(FIRST_DIV);
                    r_sq  <= SW'(FIRST_DIV * FIRST_DIV);
                    r_exp <= '0;
                end
            end
            OP_DIV_APPLY: begin
                r_rem <= div_quot;
                r_exp <= r_exp + 1'b1;
            end
            OP_STAGE: begin
                if (out_free) begin
                    r_pend_f <= 32'(r_div);
                    r_pend_e <= r_exp;
                end
            end
            OP_STAGE_R: begin
                if (out_free) begin
                    r_pend_f <= 32'(r_rem);
                    r_pend_e <= 5'd1;
                end
            end
            OP_NEXT_D: begin
                // (d+1)^2 = d^2 + 2d + 1
                r_sq  <= r_sq + SW'({r_div, 1'b1});
                r_div <= r_div + 1'b1;
                r_exp <= '0;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_in_ready  = cw.op == OP_LOAD;
    assign o_out_valid = r_ov;
    assign o_factor    = r_of;
    assign o_exponent  = r_oe;
    assign o_last      = r_ol;

endmodule

`default_nettype wire

FILE: rtl/tdf_div.sv
// ----------------------------------------------------------------------------
// tdf_div: bit-serial restoring divider
// One quotient bit per step; RW steps give quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_div #(
    parameter int RW = 32,
    parameter int DW = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tdf_pkg::t_div_ctl i_ctl,
    input  wire logic [RW-1:0]     i_dividend,
    input  wire logic [DW-1:0]     i_divisor,
    output logic      [RW-1:0]     o_quot,
    output logic      [DW-1:0]     o_rem,
    output logic                   o_busy
);
    import tdf_pkg::*;

    localparam int CNTW = $clog2(RW);

    logic [CNTW-1:0] r_cnt;
    logic [RW-1:0]   r_quot;
    logic [DW-1:0]   r_part;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial = {r_part, r_quot[RW-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= CNTW'(RW - 1);
        end else if (i_ctl.step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quot <= i_dividend;
            r_part <= '0;
        end else if (i_ctl.step) begin
            r_part <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quot <= {r_quot[RW-2:0], ge};
        end
    end

    assign o_quot = r_quot;
    assign o_rem  = r_part;
    assign o_busy = r_cnt != '0;

endmodule

`default_nettype wire

FILE: rtl/tdf_chk.sv
// ----------------------------------------------------------------------------
// tdf_chk: port-level checks for the trial division factorizer
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [31:0] i_value,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_factor,
    input wire logic [4:0]  o_exponent,
    input wire logic        o_last
);

    // offered input holds until its transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_value))
        else $error("input dropped or changed before transfer");

    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_factor)
            && $stable(o_exponent) && $stable(o_last))
        else $error("output changed while stalled");

    // output register comes out of reset empty
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // exponent 0 only for inputs 0 and 1, a single last result
    a_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_exponent == 5'd0 |-> o_last && o_factor <= 32'd1)
        else $error("zero exponent on a real factor");

    // a real factor is at least 2
    a_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_exponent != 5'd0 |-> o_factor >= 32'd2)
        else $error("factor below two");

endmodule

bind trial_division_factorizer tdf_chk u_tdf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_value     (i_value),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_factor    (o_factor),
    .o_exponent  (o_exponent),
    .o_last      (o_last)
);

`default_nettype wire
